/* sv/rvcexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RVC expander package
// Opcodes, function codes, the result type and the base-format builders
// shared by the compressed instruction expander.
// ----------------------------------------------------------------------------
package rvcexp_pkg;

  // Base opcodes
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // Base funct3 / funct7 codes
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_W   = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [6:0] F7_NONE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Register numbers used implicitly by compressed forms
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // Quadrant and compressed funct3 codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_SW       = 3'd6;

  localparam logic [2:0] C1_ADDI  = 3'd0;
  localparam logic [2:0] C1_JAL   = 3'd1;
  localparam logic [2:0] C1_LI    = 3'd2;
  localparam logic [2:0] C1_LUI   = 3'd3;
  localparam logic [2:0] C1_ARITH = 3'd4;
  localparam logic [2:0] C1_J     = 3'd5;

  localparam logic [1:0] C1A_SRLI = 2'd0;
  localparam logic [1:0] C1A_SRAI = 2'd1;
  localparam logic [1:0] C1A_ANDI = 2'd2;

  localparam logic [1:0] C1R_SUB = 2'd0;
  localparam logic [1:0] C1R_XOR = 2'd1;
  localparam logic [1:0] C1R_OR  = 2'd2;

  localparam logic [2:0] C2_SLLI = 3'd0;
  localparam logic [2:0] C2_LWSP = 3'd2;
  localparam logic [2:0] C2_MISC = 3'd4;
  localparam logic [2:0] C2_SWSP = 3'd6;

  typedef struct packed {
    logic [31:0] expanded;
    logic        illegal;
  } rvcexp_res_t;

  function automatic logic [31:0] mk_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] mk_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                       logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] mk_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [6:0] op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  function automatic logic [31:0] mk_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [6:0] op);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
  endfunction

  function automatic logic [31:0] mk_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] mk_j(logic [20:0] imm, logic [4:0] rd, logic [6:0] op);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
  endfunction

endpackage

/* sv/rvcexp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RVC expander input channel
// Valid/ready channel carrying one compressed halfword per transfer.
// ----------------------------------------------------------------------------
interface rvcexp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] compressed;

  modport source (output valid, output compressed, input ready);
  modport sink (input valid, input compressed, output ready);
endinterface

/* sv/rvcexp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RVC expander output channel
// Valid/ready channel carrying one expanded word and its illegal flag.
// ----------------------------------------------------------------------------
interface rvcexp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] expanded;
  logic        illegal;

  modport source (output valid, output expanded, output illegal, input ready);
  modport sink (input valid, input expanded, input illegal, output ready);
endinterface

/* sv/rvcexp_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RVC expander decoder
// Combinational translation of one compressed halfword into its 32-bit base
// instruction, with the illegal flag. The word is forced to zero when illegal.
// ----------------------------------------------------------------------------
module rvcexp_decoder (
  input  logic [15:0]              compressed_i,
  output rvcexp_pkg::rvcexp_res_t  res_o
);
  import rvcexp_pkg::*;

  logic [15:0] h;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rp;
  logic [4:0]  rq;
  logic [2:0]  f3;
  logic [11:0] imm6;
  logic        imm6_zero;
  logic [31:0] word;
  logic        ill;

  assign h         = compressed_i;
  assign rd        = h[11:7];
  assign rs2       = h[6:2];
  assign rp        = {2'b01, h[9:7]};
  assign rq        = {2'b01, h[4:2]};
  assign f3        = h[15:13];
  assign imm6      = {{6{h[12]}}, h[12], h[6:2]};
  // C.LUI and C.ADDI16SP draw their immediates from the same bits.
  assign imm6_zero = (h[12] == 1'b0) && (h[6:2] == 5'd0);

  always_comb begin
    word = '0;
    ill  = 1'b0;
    case (h[1:0])
      QUAD_0: begin
        case (f3)
          C0_ADDI4SPN: begin
            ill  = (h[12:5] == 8'd0);
            word = mk_i({2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00},
                        REG_SP, F3_ADD, rq, OP_IMM);
          end
          C0_LW: begin
            word = mk_i({5'd0, h[5], h[12:10], h[6], 2'b00}, rp, F3_W, rq, OP_LOAD);
          end
          C0_SW: begin
            word = mk_s({5'd0, h[5], h[12:10], h[6], 2'b00}, rq, rp, F3_W, OP_STORE);
          end
          default: ill = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (f3)
          C1_ADDI: word = mk_i(imm6, rd, F3_ADD, rd, OP_IMM);
          C1_JAL, C1_J: begin
            word = mk_j({{10{h[12]}}, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0},
                        (f3 == C1_JAL) ? REG_RA : REG_ZERO, OP_JAL);
          end
          C1_LI: word = mk_i(imm6, REG_ZERO, F3_ADD, rd, OP_IMM);
          C1_LUI: begin
            ill = imm6_zero;
            if (rd == REG_SP) begin
              word = mk_i({{3{h[12]}}, h[4:3], h[5], h[2], h[6], 4'd0},
                          REG_SP, F3_ADD, REG_SP, OP_IMM);
            end else begin
              word = mk_u({{8{h[12]}}, imm6}, rd, OP_LUI);
            end
          end
          C1_ARITH: begin
            case (h[11:10])
              C1A_SRLI: begin
                ill  = h[12];
                word = mk_i({7'd0, h[6:2]}, rp, F3_SR, rp, OP_IMM);
              end
              C1A_SRAI: begin
                ill  = h[12];
                word = mk_i({F7_ALT, h[6:2]}, rp, F3_SR, rp, OP_IMM);
              end
              C1A_ANDI: word = mk_i(imm6, rp, F3_AND, rp, OP_IMM);
              default: begin
                // Register-register forms; bit 12 set selects RV64-only ops.
                ill = h[12];
                case (h[6:5])
                  C1R_SUB: word = mk_r(F7_ALT, rq, rp, F3_ADD, rp, OP_REG);
                  C1R_XOR: word = mk_r(F7_NONE, rq, rp, F3_XOR, rp, OP_REG);
                  C1R_OR:  word = mk_r(F7_NONE, rq, rp, F3_OR, rp, OP_REG);
                  default: word = mk_r(F7_NONE, rq, rp, F3_AND, rp, OP_REG);
                endcase
              end
            endcase
          end
          default: begin
            // C.BEQZ and C.BNEZ; bit 13 picks BNE.
            word = mk_b({{5{h[12]}}, h[6:5], h[2], h[11:10], h[4:3], 1'b0},
                        REG_ZERO, rp, {2'b00, h[13]}, OP_BRANCH);
          end
        endcase
      end
      QUAD_2: begin
        case (f3)
          C2_SLLI: begin
            ill  = h[12];
            word = mk_i({7'd0, rs2}, rd, F3_SLL, rd, OP_IMM);
          end
          C2_LWSP: begin
            ill  = (rd == REG_ZERO);
            word = mk_i({4'd0, h[3:2], h[12], h[6:4], 2'b00}, REG_SP, F3_W, rd, OP_LOAD);
          end
          C2_MISC: begin
            if (h[12] == 1'b0) begin
              if (rs2 == REG_ZERO) begin
                ill  = (rd == REG_ZERO);
                word = mk_i(12'd0, rd, F3_ADD, REG_ZERO, OP_JALR);
              end else begin
                word = mk_r(F7_NONE, rs2, REG_ZERO, F3_ADD, rd, OP_REG);
              end
            end else if (rs2 == REG_ZERO) begin
              if (rd == REG_ZERO) begin
                word = mk_i(12'd1, REG_ZERO, F3_ADD, REG_ZERO, OP_SYSTEM);
              end else begin
                word = mk_i(12'd0, rd, F3_ADD, REG_RA, OP_JALR);
              end
            end else begin
              word = mk_r(F7_NONE, rs2, rd, F3_ADD, rd, OP_REG);
            end
          end
          C2_SWSP: begin
            word = mk_s({4'd0, h[8:7], h[12:9], 2'b00}, rs2, REG_SP, F3_W, OP_STORE);
          end
          default: ill = 1'b1;
        endcase
      end
      default: ill = 1'b1;
    endcase
    if (ill) begin
      word = '0;
    end
  end

  assign res_o.expanded = word;
  assign res_o.illegal  = ill;

endmodule

/* sv/rv32c_instruction_expander_unit.sv */
`timescale 1ns / 1ps
// A transfer is held in the input register, then expanded into the result register.
// Throughput: one halfword per cycle; both pipeline registers advance together
// whenever the output side takes its result, so a stall only holds occupied stages.
// Reset clears both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// RV32C instruction expander
// Input register, combinational expansion and result register, with
// valid/ready flow control on both sides.
// ----------------------------------------------------------------------------
module rv32c_instruction_expander_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvcexp_in_if.sink  cmp_i,
  rvcexp_out_if.source exp_o
);
  import rvcexp_pkg::*;

  logic        in_vld_q;
  logic [15:0] in_cmp_q;
  logic        out_vld_q;
  rvcexp_res_t out_res_q;
  rvcexp_res_t dec_res;
  logic        out_rdy;
  logic        in_rdy;

  rvcexp_decoder u_dec (
    .compressed_i (in_cmp_q),
    .res_o        (dec_res)
  );

  // A stage may load when it is empty or its content moves on this cycle.
  assign out_rdy = !out_vld_q || exp_o.ready;
  assign in_rdy  = !in_vld_q || out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_q <= cmp_i.valid;
      end
      if (out_rdy) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && cmp_i.valid) begin
      in_cmp_q <= cmp_i.compressed;
    end
    if (out_rdy && in_vld_q) begin
      out_res_q <= dec_res;
    end
  end

  assign cmp_i.ready    = in_rdy;
  assign exp_o.valid    = out_vld_q;
  assign exp_o.expanded = out_res_q.expanded;
  assign exp_o.illegal  = out_res_q.illegal;

endmodule
